/* design/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W  = 11;                         // width of the frame size registers
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;                         // 9 * 255
  localparam int CNT_W  = 4;                          // neighbour count up to 9
  localparam int NUM_W  = 13;                         // 2 * sum + count
  localparam int RCP_W  = 18;                         // reciprocal scale bits
  localparam int PRD_W  = NUM_W + RCP_W;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_SUM,
    S_DIV
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;      // latch item, start line store read
    logic step;      // shift window, write line store, advance position
    logic sum;       // register channel sums
    logic out_load;  // divide and load the output register
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic ignore;    // flush during the frame
    logic has_out;   // current step produces a result
    logic out_free;
  } status_t;

  // ceil(2^RCP_W / (2 * n)) for the possible neighbour counts
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    case (n)
      4'd1:    r = RCP_W'(131072);
      4'd2:    r = RCP_W'(65536);
      4'd3:    r = RCP_W'(43691);
      4'd4:    r = RCP_W'(32768);
      4'd6:    r = RCP_W'(21846);
      4'd9:    r = RCP_W'(14564);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (r == '0) r = DIM_W'(1);
    if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

/* design/bb3_if.sv */
// ----------------------------------------------------------------------------
// bb3 stream interfaces
// Pixel input and blurred pixel output channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       flush;

  modport source (output valid, red_in, green_in, blue_in, flush, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

interface bb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, red_out, green_out, blue_out, row_end, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, row_end, frame_end,
                  output ready);
endinterface

/* design/box_blur_3x3_rgb.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of an RGB888 raster.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order; each output channel is the rounded mean of
// that channel over the in-frame 3x3 neighbourhood. Results lag one row plus
// one pixel; after the frame, width + 1 flush items drain the tail. Every
// item passes line store read and window step; one that yields a result also
// gets a sum and a reciprocal divide, which waits for a free output register.
// The sequencer takes no new item before the last is done; a flush during the
// frame is dropped without a step. Writing a size register restarts the frame.
module box_blur_3x3_rgb (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bb3_pkg::DIM_W-1:0] cfg_data_i,
  bb3_in_if.sink                    in_i,
  bb3_out_if.source                 out_o
);

  bb3_pkg::cmd_t    cmd;
  bb3_pkg::status_t status;

  bb3_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  bb3_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

/* design/bb3_ram.sv */
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bb3_ctrl.sv */
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer of the box blur: load, step, sum, divide.
// ----------------------------------------------------------------------------
module bb3_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bb3_pkg::status_t status_i,
  output bb3_pkg::cmd_t    cmd_o
);

  bb3_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bb3_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bb3_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid && !status_i.ignore) begin
          cmd_o.load = 1'b1;
          state_d    = bb3_pkg::S_STEP;
        end
      end
      bb3_pkg::S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.has_out ? bb3_pkg::S_SUM : bb3_pkg::S_IDLE;
      end
      bb3_pkg::S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = bb3_pkg::S_DIV;
      end
      bb3_pkg::S_DIV: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bb3_pkg::S_IDLE;
        end
      end
      default: state_d = bb3_pkg::S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.in_ready |-> state_q == bb3_pkg::S_IDLE)
    else $error("input ready outside idle");

  a_step_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.step)
    else $error("load not followed by step");

  a_div_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sum |=> state_q == bb3_pkg::S_DIV)
    else $error("sum not followed by divide");

endmodule

/* design/bb3_dpath.sv */
// ----------------------------------------------------------------------------
// bb3_dpath
// Datapath of the box blur: frame position, line store, window, sums,
// reciprocal divide and output register.
// ----------------------------------------------------------------------------
module bb3_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bb3_pkg::DIM_W-1:0]   cfg_data_i,
  bb3_in_if.sink                      in_i,
  bb3_out_if.source                   out_o,
  input  bb3_pkg::cmd_t               cmd_i,
  output bb3_pkg::status_t            status_o
);

  localparam int DIM_W = bb3_pkg::DIM_W;
  localparam int COL_W = bb3_pkg::COL_W;
  localparam int ROW_W = bb3_pkg::ROW_W;
  localparam int CH_W  = bb3_pkg::CH_W;
  localparam int PIX_W = bb3_pkg::PIX_W;
  localparam int SUM_W = bb3_pkg::SUM_W;
  localparam int CNT_W = bb3_pkg::CNT_W;
  localparam int NUM_W = bb3_pkg::NUM_W;
  localparam int RCP_W = bb3_pkg::RCP_W;
  localparam int PRD_W = bb3_pkg::PRD_W;
  localparam int CW    = DIM_W + 1;                   // compare width

  localparam logic [DIM_W-1:0] MaxW = DIM_W'(bb3_pkg::MAX_WIDTH);
  localparam logic [DIM_W-1:0] MaxH = DIM_W'(bb3_pkg::MAX_HEIGHT);

  typedef struct packed {
    logic has_out;
    logic rlo1;
    logic rhi2;
    logic clo1;
    logic chi2;
    logic row_end;
    logic frame_end;
  } mask_t;

  logic [DIM_W-1:0] w_q, h_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] pix_q;
  mask_t            mk_q, mk_d;
  logic [SUM_W-1:0] sum_q [3];
  logic [CNT_W-1:0] n_q;
  logic             out_valid_q;
  logic [CH_W-1:0]  res_q [3];
  logic             row_end_q, frame_end_q;

  logic [CW-1:0]    wx, hx, xx, rx;
  logic [COL_W-1:0] x_eff;
  logic             drain;
  logic             accept;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [CW-1:0]    cr, cc;
  logic             col0_out, norm_out;

  // clamped sizes and current position, one bit wider for compares
  assign wx    = CW'(w_q);
  assign hx    = CW'(h_q);
  assign x_eff = (CW'(col_q) >= wx) ? '0 : col_q;
  assign xx    = CW'(x_eff);
  assign rx    = CW'(row_q);
  assign drain = rx >= hx;

  assign accept = in_i.valid && cmd_i.in_ready;

  assign status_o.in_valid = in_i.valid;
  assign status_o.ignore   = !drain && in_i.flush;
  assign status_o.out_free = !out_valid_q || out_o.ready;
  assign status_o.has_out  = mk_d.has_out;
  assign in_i.ready        = cmd_i.in_ready;

  // older row in the upper half, newer row in the lower half
  bb3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (bb3_pkg::MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .en_i    (cmd_i.load || cmd_i.step),
    .we_i    (cmd_i.step),
    .addr_i  (x_eff),
    .wdata_i ({ram_rdata[PIX_W-1:0], pix_q}),
    .rdata_o (ram_rdata)
  );

  // result of this step: column 0 closes the row two back, others the row one back
  always_comb begin
    mk_d     = '0;
    col0_out = (xx == '0) && (rx >= CW'(2)) && (rx <= hx + CW'(1));
    norm_out = (xx != '0) && (rx >= CW'(1)) && (rx <= hx);
    cr       = '0;
    cc       = '0;
    if (col0_out) begin
      cr        = rx - CW'(2);
      cc        = wx - CW'(1);
      mk_d.clo1 = wx < CW'(2);
      mk_d.chi2 = 1'b0;
    end else begin
      cr        = rx - CW'(1);
      cc        = xx - CW'(1);
      mk_d.clo1 = cc == '0;
      mk_d.chi2 = 1'b1;
    end
    mk_d.has_out   = col0_out || norm_out;
    mk_d.rlo1      = cr == '0;
    mk_d.rhi2      = cr + CW'(2) <= hx;
    mk_d.row_end   = cc == wx - CW'(1);
    mk_d.frame_end = mk_d.row_end && (cr == hx - CW'(1));
  end

  // configuration, position and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= bb3_pkg::WIDTH_RESET;
      h_q   <= bb3_pkg::HEIGHT_RESET;
      col_q <= '0;
      row_q <= '0;
      mk_q  <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bb3_pkg::CFG_WIDTH) begin
        w_q <= bb3_pkg::clamp_dim(cfg_data_i, MaxW);
      end else begin
        h_q <= bb3_pkg::clamp_dim(cfg_data_i, MaxH);
      end
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.step) begin
      mk_q <= mk_d;
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
      win_q[1][2] <= ram_rdata[PIX_W-1:0];
      win_q[2][2] <= pix_q;
      if (rx >= hx + CW'(1)) begin
        col_q <= '0;
        row_q <= '0;
      end else if (xx + CW'(1) >= wx) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= x_eff + COL_W'(1);
      end
    end
  end

  // item payload, drain ticks carry a zero pixel
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= drain ? '0 : {in_i.red_in, in_i.green_in, in_i.blue_in};
    end
  end

  // masked channel sums and neighbour count
  always_ff @(posedge clk_i) begin
    logic [2:0]       rsel, csel;
    logic [SUM_W-1:0] acc;
    logic [1:0]       nr, nc;
    if (cmd_i.sum) begin
      rsel = {mk_q.rhi2, 1'b1, !mk_q.rlo1};
      csel = {mk_q.chi2, 1'b1, !mk_q.clo1};
      for (int k = 0; k < 3; k++) begin
        acc = '0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (rsel[r] && csel[c]) begin
              acc = acc + SUM_W'(win_q[r][c][(2-k)*CH_W +: CH_W]);
            end
          end
        end
        sum_q[k] <= acc;
      end
      nr  = 2'd1 + 2'(rsel[0]) + 2'(rsel[2]);
      nc  = 2'd1 + 2'(csel[0]) + 2'(csel[2]);
      n_q <= CNT_W'(nr) * CNT_W'(nc);
    end
  end

  // rounded mean by reciprocal multiply, into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NUM_W-1:0] num;
    logic [PRD_W-1:0] prd;
    if (cmd_i.out_load) begin
      for (int k = 0; k < 3; k++) begin
        num      = {sum_q[k], 1'b0} + NUM_W'(n_q);
        prd      = PRD_W'(num) * PRD_W'(bb3_pkg::recip(n_q));
        res_q[k] <= prd[RCP_W +: CH_W];
      end
      row_end_q   <= mk_q.row_end;
      frame_end_q <= mk_q.frame_end;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.red_out   = res_q[0];
  assign out_o.green_out = res_q[1];
  assign out_o.blue_out  = res_q[2];
  assign out_o.row_end   = row_end_q;
  assign out_o.frame_end = frame_end_q;

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(col_q) < wx)
    else $error("column beyond frame width");

  a_row_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx <= hx + CW'(1))
    else $error("row beyond drain");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> row_end_q)
    else $error("frame end without row end");

endmodule

/* tb/sv/tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench pixel record
// Blurred pixel record as the testbench predicts and checks it.
// ----------------------------------------------------------------------------
// the block's own interfaces, bb3_in_if and bb3_out_if, are used directly;
// this file only carries the pixel record shared by the testbench
package tb_pix_pkg;
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } blur_px_t;
endpackage

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the streaming 3x3 RGB box blur: frames of random
// and extreme sizes and content, with drain items, ignored flushes and random
// handshake gaps, compared item by item against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;

  class blur_scoreboard;
    int unsigned                   frame_w, frame_h;
    logic [bb3_pkg::PIX_W-1:0]     line_old [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0]     line_new [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0]     win [3][3];
    int unsigned                   col, row;
    tb_pix_pkg::blur_px_t          pending_px[$];
    int                            errors;
    int                            px_seen;

    function new();
      frame_w = 640; frame_h = 480;
      foreach (line_old[i]) begin
        line_old[i] = '0; line_new[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      col = 0; row = 0; errors = 0; px_seen = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned m);
      v = v & 11'h7ff;
      if (v < 1) v = 1;
      if (v > m) v = m;
      return v;
    endfunction

    function void set_size(bb3_pkg::cfg_idx_e idx, int unsigned v);
      if (idx == bb3_pkg::CFG_WIDTH) frame_w = v & 11'h7ff;
      else frame_h = v & 11'h7ff;
      col = 0; row = 0;
    endfunction

    function void mean(int r0, int r2, int c0, int c2, output tb_pix_pkg::blur_px_t p);
      int unsigned s[3];
      int unsigned n;
      s = '{0, 0, 0}; n = 0;
      for (int r = r0; r <= r2; r++)
        for (int c = c0; c <= c2; c++) begin
          s[0] += win[r][c][23:16]; s[1] += win[r][c][15:8]; s[2] += win[r][c][7:0];
          n++;
        end
      p.red = 8'((2*s[0] + n) / (2*n));
      p.green = 8'((2*s[1] + n) / (2*n));
      p.blue = 8'((2*s[2] + n) / (2*n));
    endfunction

    // note one accepted input item; returns whether it yields a pixel
    function bit note_input(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
      int unsigned w, h, x, rr, cr, cc;
      logic [bb3_pkg::PIX_W-1:0] pix;
      tb_pix_pkg::blur_px_t p;
      bit drain, got;
      w = clip(frame_w, bb3_pkg::MAX_WIDTH); h = clip(frame_h, bb3_pkg::MAX_HEIGHT);
      x = col; rr = row; drain = rr >= h; got = 0; pix = '0;
      if (!drain && fl) return 0;
      if (x >= w) x = 0;
      if (!drain) pix = {r, g, b};
      // column 0 finishes the last pixel of the row two back
      if (x == 0 && rr >= 2 && rr <= h + 1) begin
        cr = rr - 2; cc = w - 1;
        mean(cr >= 1 ? 0 : 1, cr + 1 <= h - 1 ? 2 : 1, w >= 2 ? 1 : 2, 2, p);
        got = 1;
      end
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1]; win[k][1] = win[k][2];
      end
      win[0][2] = line_old[x]; win[1][2] = line_new[x]; win[2][2] = pix;
      line_old[x] = line_new[x]; line_new[x] = pix;
      if (x >= 1 && rr >= 1 && rr <= h) begin
        cr = rr - 1; cc = x - 1;
        mean(cr >= 1 ? 0 : 1, cr + 1 <= h - 1 ? 2 : 1, cc >= 1 ? 0 : 1, 2, p);
        got = 1;
      end
      if (got) begin
        p.row_end = (cc == w - 1);
        p.frame_end = p.row_end && (cr == h - 1);
        pending_px.push_back(p);
      end
      if (rr >= h + 1) begin
        col = 0; row = 0;
      end else if (x + 1 >= w) begin
        col = 0; row = rr + 1;
      end else begin
        col = x + 1;
      end
      return got;
    endfunction

    function void check_output(tb_pix_pkg::blur_px_t got);
      tb_pix_pkg::blur_px_t exp_px;
      px_seen++;
      if (pending_px.size() == 0) begin
        report("pixel with nothing pending", 0, 0);
        return;
      end
      exp_px = pending_px.pop_front();
      if (got.red != exp_px.red) report("red", got.red, exp_px.red);
      if (got.green != exp_px.green) report("green", got.green, exp_px.green);
      if (got.blue != exp_px.blue) report("blue", got.blue, exp_px.blue);
      if (got.row_end != exp_px.row_end) report("row_end", got.row_end, exp_px.row_end);
      if (got.frame_end != exp_px.frame_end)
        report("frame_end", got.frame_end, exp_px.frame_end);
    endfunction

    function void report(string what, int got, int want);
      errors++;
      if (errors <= 30)
        $display("mismatch #%0d at %0t: %s got %0d want %0d", errors, $realtime,
                 what, got, want);
    endfunction
  endclass

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [bb3_pkg::DIM_W-1:0] cfg_data_i = '0;

  bb3_in_if  pix_in ();
  bb3_out_if pix_out ();

  box_blur_3x3_rgb dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(pix_in.sink), .out_o(pix_out.source)
  );

  blur_scoreboard sb = new();
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit stim_done = 0;

  initial begin
    pix_in.valid = 1'b0; pix_in.red_in = '0; pix_in.green_in = '0;
    pix_in.blue_in = '0; pix_in.flush = 1'b0;
    pix_out.ready = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one item; the valid stays up between back-to-back items
  task automatic send_px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl,
                         bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.red_in <= r; pix_in.green_in <= g; pix_in.blue_in <= b; pix_in.flush <= fl;
    do @(posedge clk_i); while (!(pix_in.ready === 1'b1));
    void'(sb.note_input(r, g, b, fl));
    items_sent++;
  endtask

  task automatic drain_out();
    pix_in.valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_size(bb3_pkg::cfg_idx_e idx, int unsigned v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= bb3_pkg::DIM_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_size(idx, v);
  endtask

  // a whole frame plus its drain; mode 0 random, 1 all ones, 2 all zeros
  task automatic send_frame(int w, int h, int mode, bit noise);
    logic [7:0] r, g, b;
    for (int i = 0; i < w * h; i++) begin
      r = $urandom; g = $urandom; b = $urandom;
      if (mode == 1) {r, g, b} = '1;
      if (mode == 2) {r, g, b} = '0;
      if (noise && $urandom_range(0, 9) == 0) send_px(r, g, b, 1'b1);
      send_px(r, g, b, 1'b0);
    end
    for (int i = 0; i < w + 1; i++)
      send_px($urandom, $urandom, $urandom, noise ? 1'($urandom) : 1'b1);
  endtask

  task automatic frame_at(int w, int h, int mode, bit noise);
    write_size(bb3_pkg::CFG_WIDTH, w);
    write_size(bb3_pkg::CFG_HEIGHT, h);
    send_frame(w, h, mode, noise);
    drain_out();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: tiny and degenerate sizes, extremes of the data
    frame_at(1, 1, 1, 0);
    frame_at(3, 3, 1, 0);
    frame_at(2, 2, 2, 0);
    frame_at(1, 4, 0, 1);
    frame_at(4, 1, 0, 1);
    // out-of-range sizes clamp to 1 and to the maximum
    write_size(bb3_pkg::CFG_WIDTH, 0);
    write_size(bb3_pkg::CFG_HEIGHT, 2047);
    write_size(bb3_pkg::CFG_HEIGHT, 2);
    send_frame(1, 2, 0, 0);
    drain_out();
    // tall clamped frame, cut short by the next size write
    write_size(bb3_pkg::CFG_HEIGHT, 2047);
    for (int i = 0; i < 20; i++) send_px($urandom, $urandom, $urandom, 1'b0);
    drain_out();
    // restart mid frame
    write_size(bb3_pkg::CFG_WIDTH, 5);
    write_size(bb3_pkg::CFG_HEIGHT, 4);
    for (int i = 0; i < 7; i++) send_px($urandom, $urandom, $urandom, 1'b0);
    drain_out();
    // random frames
    while (items_sent < 430)
      frame_at($urandom_range(1, 9), $urandom_range(1, 7), 0, 1);
    frame_at(6, 5, 0, 0);
    stim_done = 1;
  end

  // sink side: random stalls, one long hold-off
  initial begin
    int w;
    repeat (12) @(posedge clk_i);
    forever begin
      if (items_sent > 300 && items_sent < 320 && hold_off == 0) begin
        hold_off = 1;
        pix_out.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      if (items_sent > 450) w = 0;
      if (w > 0) begin
        pix_out.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      pix_out.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
      sb.check_output('{pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                        pix_out.row_end, pix_out.frame_end});
  end

  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    repeat (20) @(posedge clk_i);
    if (sb.pending_px.size() != 0)
      sb.report("pixels never delivered", 0, sb.pending_px.size());
    $display("covered %0d input items and %0d blurred pixels", items_sent, sb.px_seen);
    $display("frames from 1x1 to 9x7, clamped sizes, restarts and a long output stall");
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
